// File: src/bounded_double_ended_queue_core_defines.svh
// assertion macros for the deque core checker
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define BDEQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque core check failed");

// next-cycle implication, clocked on clk, off during reset
`define BDEQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque core check failed");

`endif

// File: src/bdeq_pkg.sv
// shared types and constants of the deque core
package bdeq_pkg;

    localparam int CAP_W  = 11;
    localparam int CMD_W  = 3;
    localparam int DATA_W = 32;

    localparam logic [CAP_W-1:0]         CAP_RESET   = 11'd1024;
    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_QUERY      = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

// File: src/bdeq_if.sv
// command and response channel interfaces of the deque core
interface bdeq_req_if;
    logic                                valid;
    logic                                ready;
    logic [bdeq_pkg::CMD_W-1:0]          cmd;
    logic signed [bdeq_pkg::DATA_W-1:0]  value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink (input valid, input cmd, input value, output ready);
endinterface

interface bdeq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                accepted;
    logic signed [bdeq_pkg::DATA_W-1:0]  front_value;
    logic signed [bdeq_pkg::DATA_W-1:0]  rear_value;
    logic                                is_empty;
    logic                                is_full;
    logic [bdeq_pkg::CAP_W-1:0]          occupancy_out;

    modport source (
        output valid, output accepted, output front_value, output rear_value,
        output is_empty, output is_full, output occupancy_out, input ready
    );
    modport sink (
        input valid, input accepted, input front_value, input rear_value,
        input is_empty, input is_full, input occupancy_out, output ready
    );
endinterface

// File: src/bounded_double_ended_queue_core.sv
// bounded deque core: ring storage in one memory, front/rear indices and a count
//
// channel  | dir | handshake      | payload
// ---------+-----+----------------+-----------------------------------------------
// req      | in  | valid/ready    | cmd, value
// rsp      | out | valid/ready    | accepted, front_value, rear_value, is_empty,
//          |     |                | is_full, occupancy_out
// cfg      | in  | cfg_we         | cfg_data (capacity)
//
// a command runs through update and memory write, registered read of the
// front and rear slots and load of the response register, in that order
// the two memory read ports are registered; one command is in flight at a time
// a stalled rsp holds the core in its last step; req is taken again once the
// response register is loaded, even while that response is still waiting
// reset clears indices and count and sets capacity to 1024; the memory is not cleared
module bounded_double_ended_queue_core #(
    parameter int DEPTH       = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bdeq_pkg::CAP_W-1:0]    cfg_data,
    bdeq_req_if.sink                      req,
    bdeq_rsp_if.source                    rsp
);

    localparam int AW    = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (OCC_W > bdeq_pkg::CAP_W) ? OCC_W : bdeq_pkg::CAP_W;
    localparam int EXT_W = (VALUE_WIDTH > bdeq_pkg::DATA_W) ? VALUE_WIDTH : bdeq_pkg::DATA_W;
    localparam logic [AW-1:0]    LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(DEPTH);

    bdeq_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                  front_reg, front_next;
    logic [AW-1:0]                  rear_reg, rear_next;
    logic [OCC_W-1:0]               occ_reg, occ_next;
    logic                           ok_reg, ok_next;
    logic [bdeq_pkg::CAP_W-1:0]     cap_reg;

    logic [VALUE_WIDTH-1:0]         entry_mem [DEPTH];
    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [VALUE_WIDTH-1:0]         mem_wdata;
    logic signed [VALUE_WIDTH-1:0]  rd_front_reg;
    logic signed [VALUE_WIDTH-1:0]  rd_rear_reg;

    logic                                rsp_valid_reg;
    logic                                accepted_reg;
    logic signed [bdeq_pkg::DATA_W-1:0]  front_value_reg;
    logic signed [bdeq_pkg::DATA_W-1:0]  rear_value_reg;
    logic                                is_empty_reg;
    logic                                is_full_reg;
    logic [bdeq_pkg::CAP_W-1:0]          occupancy_out_reg;

    logic                    req_ready;
    logic                    take;
    logic                    load_out;
    logic [AW-1:0]           front_inc, front_dec, rear_inc, rear_dec;
    logic [CMP_W-1:0]        cap_ext, eff_cap, occ_ext;
    logic                    has_room, nonempty;
    logic signed [EXT_W-1:0] v_ext, f_ext, r_ext;

    // index and limit arithmetic
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign rear_inc  = (rear_reg == LAST_IDX) ? '0 : rear_reg + 1'b1;
    assign rear_dec  = (rear_reg == '0) ? LAST_IDX : rear_reg - 1'b1;

    assign cap_ext  = CMP_W'(cap_reg);
    assign eff_cap  = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
    assign occ_ext  = CMP_W'(occ_reg);
    assign has_room = occ_ext < eff_cap;
    assign nonempty = occ_reg != '0;

    assign v_ext     = EXT_W'(req.value);
    assign mem_wdata = v_ext[VALUE_WIDTH-1:0];
    assign f_ext     = EXT_W'(rd_front_reg);
    assign r_ext     = EXT_W'(rd_rear_reg);

    assign take = req.valid && req_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bdeq_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = bdeq_pkg::ST_READ;
                end
            end
            bdeq_pkg::ST_READ:
            begin
                state_next = bdeq_pkg::ST_DONE;
            end
            bdeq_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = bdeq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bdeq_pkg::ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        req_ready = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            bdeq_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            bdeq_pkg::ST_DONE:
            begin
                load_out = !rsp_valid_reg || rsp.ready;
            end
            default:
            begin
                req_ready = 1'b0;
                load_out  = 1'b0;
            end
        endcase
    end

    // command decode: index update and memory write
    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        occ_next   = occ_reg;
        ok_next    = ok_reg;
        mem_we     = 1'b0;
        mem_waddr  = rear_reg;
        if (take)
        begin
            ok_next = 1'b1;
            case (req.cmd)
                bdeq_pkg::CMD_PUSH_FRONT:
                begin
                    if (has_room)
                    begin
                        front_next = front_dec;
                        mem_we     = 1'b1;
                        mem_waddr  = front_dec;
                        occ_next   = occ_reg + 1'b1;
                    end
                    else
                    begin
                        ok_next = 1'b0;
                    end
                end
                bdeq_pkg::CMD_PUSH_REAR:
                begin
                    if (has_room)
                    begin
                        rear_next = rear_inc;
                        mem_we    = 1'b1;
                        mem_waddr = rear_reg;
                        occ_next  = occ_reg + 1'b1;
                    end
                    else
                    begin
                        ok_next = 1'b0;
                    end
                end
                bdeq_pkg::CMD_POP_FRONT:
                begin
                    if (nonempty)
                    begin
                        front_next = front_inc;
                        occ_next   = occ_reg - 1'b1;
                    end
                    else
                    begin
                        ok_next = 1'b0;
                    end
                end
                bdeq_pkg::CMD_POP_REAR:
                begin
                    if (nonempty)
                    begin
                        rear_next = rear_dec;
                        occ_next  = occ_reg - 1'b1;
                    end
                    else
                    begin
                        ok_next = 1'b0;
                    end
                end
                default:
                begin
                    ok_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdeq_pkg::ST_IDLE;
            front_reg <= '0;
            rear_reg  <= '0;
            occ_reg   <= '0;
            ok_reg    <= 1'b0;
            cap_reg   <= bdeq_pkg::CAP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            rear_reg  <= rear_next;
            occ_reg   <= occ_next;
            ok_reg    <= ok_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // entry memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_front_reg <= entry_mem[front_reg];
        rd_rear_reg  <= entry_mem[rear_dec];
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            accepted_reg      <= ok_reg;
            is_empty_reg      <= !nonempty;
            is_full_reg       <= occ_ext >= eff_cap;
            occupancy_out_reg <= occ_ext[bdeq_pkg::CAP_W-1:0];
            front_value_reg   <= nonempty ? f_ext[bdeq_pkg::DATA_W-1:0] : bdeq_pkg::EMPTY_VALUE;
            rear_value_reg    <= nonempty ? r_ext[bdeq_pkg::DATA_W-1:0] : bdeq_pkg::EMPTY_VALUE;
        end
    end

    assign req.ready         = req_ready;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.accepted      = accepted_reg;
    assign rsp.front_value   = front_value_reg;
    assign rsp.rear_value    = rear_value_reg;
    assign rsp.is_empty      = is_empty_reg;
    assign rsp.is_full       = is_full_reg;
    assign rsp.occupancy_out = occupancy_out_reg;

endmodule

// File: src/bdeq_checker.sv
// port-level checks of the deque core and their bind
`include "bounded_double_ended_queue_core_defines.svh"

module bdeq_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                req_valid,
    input logic                                req_ready,
    input logic                                rsp_valid,
    input logic                                rsp_ready,
    input logic                                rsp_accepted,
    input logic signed [bdeq_pkg::DATA_W-1:0]  rsp_front_value,
    input logic signed [bdeq_pkg::DATA_W-1:0]  rsp_rear_value,
    input logic                                rsp_is_empty,
    input logic                                rsp_is_full,
    input logic [bdeq_pkg::CAP_W-1:0]          rsp_occupancy_out
);

    // held response keeps its payload
    `BDEQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_accepted) && $stable(rsp_front_value) && $stable(rsp_rear_value) && $stable(rsp_is_empty) && $stable(rsp_is_full) && $stable(rsp_occupancy_out))

    // one command in flight: no req transfer right after another
    `BDEQ_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

    // empty queue reports no entries and the empty marker on both ends
    `BDEQ_ASSERT_SAME(a_empty_view, rsp_valid && rsp_is_empty, rsp_occupancy_out == '0 && rsp_front_value == bdeq_pkg::EMPTY_VALUE && rsp_rear_value == bdeq_pkg::EMPTY_VALUE)

    // non-empty queue reports a nonzero count
    `BDEQ_ASSERT_SAME(a_count_nonzero, rsp_valid && !rsp_is_empty, rsp_occupancy_out != '0)

endmodule

bind bounded_double_ended_queue_core bdeq_checker u_bdeq_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_accepted      (rsp.accepted),
    .rsp_front_value   (rsp.front_value),
    .rsp_rear_value    (rsp.rear_value),
    .rsp_is_empty      (rsp.is_empty),
    .rsp_is_full       (rsp.is_full),
    .rsp_occupancy_out (rsp.occupancy_out)
);
